FILE: hdl/wpp_pkg.sv
// ----------------------------------------------------------------------------
// wpp_pkg
// Shared types and constants for the WAV PCM stream parser: parse phases,
// result status codes, chunk identifiers and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package wpp_pkg;

    // Little-endian chunk identifiers as they appear when four bytes are packed.
    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    // Accepted fmt chunk sizes and the extra bytes each one carries.
    localparam logic [31:0] FMT_SIZE_BASIC = 32'd16;
    localparam logic [31:0] FMT_SIZE_EXT   = 32'd18;
    localparam logic [31:0] FMT_SIZE_LONG  = 32'd40;
    localparam logic [31:0] EXTRA_EXT      = FMT_SIZE_EXT - FMT_SIZE_BASIC;
    localparam logic [31:0] EXTRA_LONG     = FMT_SIZE_LONG - FMT_SIZE_BASIC;

    // Field values checked in the fmt chunk.
    localparam logic [31:0] FORMAT_PCM     = 32'd1;
    localparam logic [31:0] CHANNELS_MONO  = 32'd1;
    localparam logic [31:0] CHANNELS_DUAL  = 32'd2;
    localparam logic [31:0] BITS_NARROW    = 32'd8;
    localparam logic [31:0] BITS_WIDE      = 32'd16;

    typedef enum logic [4:0] {
        PH_RIFF,
        PH_RIFF_SIZE,
        PH_WAVE,
        PH_FMT_SCAN,
        PH_FMT_SIZE,
        PH_FORMAT,
        PH_CHANNELS,
        PH_RATE,
        PH_BYTE_RATE,
        PH_ALIGN,
        PH_BITS,
        PH_SKIP_EXTRA,
        PH_CHUNK_ID,
        PH_CHUNK_SIZE,
        PH_SKIP_CHUNK,
        PH_DATA_SIZE,
        PH_DATA,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [3:0] {
        ST_FRAME       = 4'd0,
        ST_PARTIAL_END = 4'd1,
        ST_BAD_RIFF    = 4'd2,
        ST_BAD_WAVE    = 4'd3,
        ST_FMT_SIZE    = 4'd4,
        ST_NOT_PCM     = 4'd5,
        ST_CHANNELS    = 4'd6,
        ST_ZERO_RATE   = 4'd7,
        ST_BITS        = 4'd8
    } status_t;

    typedef struct packed {
        status_t            status;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic               end_of_data;
        logic               stereo;
        logic               sixteen_bit;
        logic [31:0]        sample_rate;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/wpp_parser.sv
// ----------------------------------------------------------------------------
// wpp_parser
// Parser state and the combinational update for one file byte. Produces a
// result record and a flag telling whether this byte yields a transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module wpp_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      file_byte,
    input  wire logic            start_of_file,
    output wpp_pkg::result_t     result,
    output logic                 emit
);
    import wpp_pkg::*;

    phase_t      phase_reg,  phase_next,  cur_phase;
    logic [1:0]  biw_reg,    biw_next,    cur_biw;
    logic [23:0] word_reg,   word_next,   cur_word;
    logic [31:0] skip_reg,   skip_next,   cur_skip;
    logic [31:0] data_reg,   data_next,   cur_data;
    logic        stereo_reg, stereo_next, cur_stereo;
    logic        wide_reg,   wide_next,   cur_wide;
    logic [31:0] rate_reg,   rate_next,   cur_rate;
    logic [23:0] frame_reg,  frame_next,  cur_frame;
    logic [1:0]  fidx_reg,   fidx_next,   cur_fidx;

    logic [31:0] ws32;
    logic [31:0] fb32;
    logic [2:0]  count;
    logic [2:0]  len;
    logic [2:0]  per_frame;
    logic [31:0] skip_dec;
    logic [31:0] data_dec;
    logic [31:0] v;

    // A start byte restarts the parser before the byte itself is parsed.
    always_comb
    begin
        if (start_of_file)
        begin
            cur_phase  = PH_RIFF;
            cur_biw    = '0;
            cur_word   = '0;
            cur_skip   = '0;
            cur_data   = '0;
            cur_stereo = 1'b0;
            cur_wide   = 1'b0;
            cur_rate   = '0;
            cur_frame  = '0;
            cur_fidx   = '0;
        end
        else
        begin
            cur_phase  = phase_reg;
            cur_biw    = biw_reg;
            cur_word   = word_reg;
            cur_skip   = skip_reg;
            cur_data   = data_reg;
            cur_stereo = stereo_reg;
            cur_wide   = wide_reg;
            cur_rate   = rate_reg;
            cur_frame  = frame_reg;
            cur_fidx   = fidx_reg;
        end
    end

    // Byte assembly for the header fields and for the sample frames.
    always_comb
    begin
        ws32 = {8'h00, cur_word} | ({24'h000000, file_byte} << {cur_biw, 3'b000});
        fb32 = {8'h00, cur_frame} | ({24'h000000, file_byte} << {cur_fidx, 3'b000});
        per_frame = (cur_wide && cur_stereo) ? 3'd4 :
                    (cur_wide || cur_stereo) ? 3'd2 : 3'd1;
        skip_dec = (cur_skip != '0) ? cur_skip - 32'd1 : cur_skip;
        data_dec = cur_data - 32'd1;
        v = ws32;
    end

    // Next state and result for the byte on the input.
    always_comb
    begin
        phase_next  = cur_phase;
        biw_next    = cur_biw;
        word_next   = cur_word;
        skip_next   = cur_skip;
        data_next   = cur_data;
        stereo_next = cur_stereo;
        wide_next   = cur_wide;
        rate_next   = cur_rate;
        frame_next  = cur_frame;
        fidx_next   = cur_fidx;
        count       = 3'd0;
        len         = 3'd4;
        emit        = 1'b0;
        result.status       = ST_FRAME;
        result.left_sample  = '0;
        result.right_sample = '0;
        result.end_of_data  = 1'b0;
        result.stereo       = cur_stereo;
        result.sixteen_bit  = cur_wide;
        result.sample_rate  = cur_rate;

        unique case (cur_phase)
            PH_ERROR, PH_DONE:
            begin
                // Bytes are ignored until the next start byte.
            end
            PH_SKIP_EXTRA, PH_SKIP_CHUNK:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_next = PH_CHUNK_ID;
                end
            end
            PH_DATA:
            begin
                count     = {1'b0, cur_fidx} + 3'd1;
                data_next = data_dec;
                if (count >= per_frame)
                begin
                    emit = 1'b1;
                    if (cur_wide)
                    begin
                        result.left_sample  = fb32[15:0];
                        result.right_sample = cur_stereo ? fb32[31:16] : 16'h0000;
                    end
                    else
                    begin
                        result.left_sample  = {8'h00, fb32[7:0]};
                        result.right_sample = cur_stereo ? {8'h00, fb32[15:8]} : 16'h0000;
                    end
                    result.end_of_data = (data_dec == '0);
                    frame_next = '0;
                    fidx_next  = '0;
                    if (data_dec == '0)
                    begin
                        phase_next = PH_DONE;
                    end
                end
                else if (data_dec == '0)
                begin
                    // Data ran out inside a frame: drop the collected bytes.
                    emit               = 1'b1;
                    result.status      = ST_PARTIAL_END;
                    result.end_of_data = 1'b1;
                    frame_next = '0;
                    fidx_next  = '0;
                    phase_next = PH_DONE;
                end
                else
                begin
                    frame_next = fb32[23:0];
                    fidx_next  = count[1:0];
                end
            end
            default:
            begin
                count = {1'b0, cur_biw} + 3'd1;
                if (cur_phase == PH_FORMAT || cur_phase == PH_CHANNELS ||
                    cur_phase == PH_ALIGN || cur_phase == PH_BITS)
                begin
                    len = 3'd2;
                end
                if (count < len)
                begin
                    biw_next  = count[1:0];
                    word_next = ws32[23:0];
                end
                else
                begin
                    biw_next  = '0;
                    word_next = '0;
                    unique case (cur_phase)
                        PH_RIFF:
                        begin
                            if (v != ID_RIFF)
                            begin
                                phase_next    = PH_ERROR;
                                emit          = 1'b1;
                                result.status = ST_BAD_RIFF;
                            end
                            else
                            begin
                                phase_next = PH_RIFF_SIZE;
                            end
                        end
                        PH_RIFF_SIZE:
                        begin
                            phase_next = PH_WAVE;
                        end
                        PH_WAVE:
                        begin
                            if (v != ID_WAVE)
                            begin
                                phase_next    = PH_ERROR;
                                emit          = 1'b1;
                                result.status = ST_BAD_WAVE;
                            end
                            else
                            begin
                                phase_next = PH_FMT_SCAN;
                            end
                        end
                        PH_FMT_SCAN:
                        begin
                            if (v == ID_FMT)
                            begin
                                phase_next = PH_FMT_SIZE;
                            end
                        end
                        PH_FMT_SIZE:
                        begin
                            phase_next = PH_FORMAT;
                            if (v == FMT_SIZE_BASIC)
                            begin
                                skip_next = '0;
                            end
                            else if (v == FMT_SIZE_EXT)
                            begin
                                skip_next = EXTRA_EXT;
                            end
                            else if (v == FMT_SIZE_LONG)
                            begin
                                skip_next = EXTRA_LONG;
                            end
                            else
                            begin
                                phase_next    = PH_ERROR;
                                emit          = 1'b1;
                                result.status = ST_FMT_SIZE;
                            end
                        end
                        PH_FORMAT:
                        begin
                            if (v != FORMAT_PCM)
                            begin
                                phase_next    = PH_ERROR;
                                emit          = 1'b1;
                                result.status = ST_NOT_PCM;
                            end
                            else
                            begin
                                phase_next = PH_CHANNELS;
                            end
                        end
                        PH_CHANNELS:
                        begin
                            if (v != CHANNELS_MONO && v != CHANNELS_DUAL)
                            begin
                                phase_next    = PH_ERROR;
                                emit          = 1'b1;
                                result.status = ST_CHANNELS;
                            end
                            else
                            begin
                                stereo_next = (v == CHANNELS_DUAL);
                                phase_next  = PH_RATE;
                            end
                        end
                        PH_RATE:
                        begin
                            if (v == '0)
                            begin
                                phase_next    = PH_ERROR;
                                emit          = 1'b1;
                                result.status = ST_ZERO_RATE;
                            end
                            else
                            begin
                                rate_next  = v;
                                phase_next = PH_BYTE_RATE;
                            end
                        end
                        PH_BYTE_RATE:
                        begin
                            phase_next = PH_ALIGN;
                        end
                        PH_ALIGN:
                        begin
                            phase_next = PH_BITS;
                        end
                        PH_BITS:
                        begin
                            if (v != BITS_NARROW && v != BITS_WIDE)
                            begin
                                phase_next    = PH_ERROR;
                                emit          = 1'b1;
                                result.status = ST_BITS;
                            end
                            else
                            begin
                                wide_next  = (v == BITS_WIDE);
                                phase_next = (cur_skip == '0) ? PH_CHUNK_ID : PH_SKIP_EXTRA;
                            end
                        end
                        PH_CHUNK_ID:
                        begin
                            phase_next = (v == ID_DATA) ? PH_DATA_SIZE : PH_CHUNK_SIZE;
                        end
                        PH_CHUNK_SIZE:
                        begin
                            skip_next  = v;
                            phase_next = (v == '0) ? PH_CHUNK_ID : PH_SKIP_CHUNK;
                        end
                        PH_DATA_SIZE:
                        begin
                            data_next  = v;
                            frame_next = '0;
                            fidx_next  = '0;
                            phase_next = (v == '0) ? PH_DONE : PH_DATA;
                        end
                        default:
                        begin
                            phase_next = PH_ERROR;
                        end
                    endcase
                end
            end
        endcase
    end

    // Parser state registers, updated once per accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_RIFF;
            biw_reg    <= '0;
            word_reg   <= '0;
            skip_reg   <= '0;
            data_reg   <= '0;
            stereo_reg <= 1'b0;
            wide_reg   <= 1'b0;
            rate_reg   <= '0;
            frame_reg  <= '0;
            fidx_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            biw_reg    <= biw_next;
            word_reg   <= word_next;
            skip_reg   <= skip_next;
            data_reg   <= data_next;
            stereo_reg <= stereo_next;
            wide_reg   <= wide_next;
            rate_reg   <= rate_next;
            frame_reg  <= frame_next;
            fidx_reg   <= fidx_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wav_pcm_stream_parser_top.sv
// ----------------------------------------------------------------------------
// wav_pcm_stream_parser_top
// Parses a WAV file delivered one byte per transaction and emits PCM frames
// or error status.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one file byte per
// transaction, with start_of_file marking the first byte of a new file.
// The output channel (out_valid/out_ready) carries at most one result per
// input byte: a sample frame, a partial-end flag or an error status.
// Each byte is parsed in the cycle it is accepted and any result appears in
// the output register on the next cycle. The block takes one byte per cycle
// while no result is stalled. The output register is the only limit:
// a new byte is taken whenever the register is empty or being read.
// When the receiver stalls with a result waiting, in_ready drops until that
// result is taken; bytes that produce no result still wait for it.
// Reset clears the parser to expect a RIFF id and empties the output
// register. Errors are reported once and then bytes are dropped until the
// next start byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_pcm_stream_parser_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         file_byte,
    input  wire logic               start_of_file,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [3:0]              status,
    output logic signed [15:0]      left_sample,
    output logic signed [15:0]      right_sample,
    output logic                    end_of_data,
    output logic                    stereo,
    output logic                    sixteen_bit,
    output logic [31:0]             sample_rate
);
    import wpp_pkg::*;

    logic    step;
    logic    emit;
    result_t result;
    result_t result_reg;
    logic    out_valid_reg;

    // A byte is taken whenever the output register is free or draining.
    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    wpp_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .file_byte     (file_byte),
        .start_of_file (start_of_file),
        .result        (result),
        .emit          (emit)
    );

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = result_reg.status;
    assign left_sample  = result_reg.left_sample;
    assign right_sample = result_reg.right_sample;
    assign end_of_data  = result_reg.end_of_data;
    assign stereo       = result_reg.stereo;
    assign sixteen_bit  = result_reg.sixteen_bit;
    assign sample_rate  = result_reg.sample_rate;

endmodule

`default_nettype wire

FILE: verif/wav_pcm_stream_parser_top_tb.sv
// ----------------------------------------------------------------------------
// wav_pcm_stream_parser_top_tb
// Self-checking bench for the WAV PCM stream parser. WAV files are built
// byte by byte (well-formed, deliberately broken and pure noise) and fed
// through the input channel in bursts, while the output channel stalls on
// its own pattern. A bit-accurate parser model predicts every frame, partial
// end and error status, and each output transaction is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module wav_pcm_stream_parser_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import wpp_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_BYTES = 800;

    // Description of one generated WAV file.
    typedef struct packed {
        logic [31:0] riff_id;
        logic [31:0] wave_id;
        logic [7:0]  junk_words;
        logic [31:0] fmt_size;
        logic [15:0] fmt_code;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [7:0]  other_chunks;
        logic [31:0] data_size;
        logic [15:0] data_len;
        logic        fixed_head;
    } wav_desc_t;

    typedef enum int {
        PACE_FREE,
        PACE_COIN,
        PACE_SPARSE,
        PACE_BEAT
    } pace_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         file_byte = 8'd0;
    logic               start_of_file = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [3:0]         status;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               end_of_data;
    logic               stereo;
    logic               sixteen_bit;
    logic [31:0]        sample_rate;

    // Predicted results not yet seen on the output, and bench bookkeeping.
    result_t     pending_results [$];
    result_t     head_result;
    logic [7:0]  file_octets [$];
    int          error_count = 0;
    int          results_seen = 0;
    int          bytes_sent = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    bit          no_gaps = 1'b0;
    pace_t       pace_mode = PACE_FREE;
    int          pace_left = 0;

    // Parser model state.
    phase_t      rx_phase;
    logic [1:0]  word_pos;
    logic [31:0] word_acc;
    logic [31:0] skip_left;
    logic [31:0] data_left;
    logic        is_stereo;
    logic        is_wide;
    logic [31:0] rate_seen;
    logic [31:0] frame_acc;
    logic [1:0]  frame_pos;

    wav_pcm_stream_parser_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .file_byte     (file_byte),
        .start_of_file (start_of_file),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .left_sample   (left_sample),
        .right_sample  (right_sample),
        .end_of_data   (end_of_data),
        .stereo        (stereo),
        .sixteen_bit   (sixteen_bit),
        .sample_rate   (sample_rate)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------

    function automatic void clear_parser();
        rx_phase  = PH_RIFF;
        word_pos  = 2'd0;
        word_acc  = 32'd0;
        skip_left = 32'd0;
        data_left = 32'd0;
        is_stereo = 1'b0;
        is_wide   = 1'b0;
        rate_seen = 32'd0;
        frame_acc = 32'd0;
        frame_pos = 2'd0;
    endfunction

    function automatic result_t make_result(input status_t st, input logic [15:0] l,
                                            input logic [15:0] r, input logic eod);
        result_t res;
        res.status       = st;
        res.left_sample  = l;
        res.right_sample = r;
        res.end_of_data  = eod;
        res.stereo       = is_stereo;
        res.sixteen_bit  = is_wide;
        res.sample_rate  = rate_seen;
        return res;
    endfunction

    // Advances the model by one byte and gives the result it causes, if any.
    task automatic parse_byte(input logic [7:0] b, input logic sof,
                              output bit has_res, output result_t res);
        int          cnt;
        int          need;
        int          per_frame;
        logic [31:0] v;
        logic [15:0] l;
        logic [15:0] r;
        bit          bad;
        status_t     err;
        has_res = 1'b0;
        res     = '0;
        bad     = 1'b0;
        err     = ST_FRAME;
        if (sof)
        begin
            clear_parser();
        end
        if (rx_phase == PH_ERROR || rx_phase == PH_DONE)
        begin
            // Latched: nothing happens until the next start byte.
        end
        else if (rx_phase == PH_SKIP_EXTRA || rx_phase == PH_SKIP_CHUNK)
        begin
            if (skip_left != 32'd0)
            begin
                skip_left = skip_left - 32'd1;
            end
            if (skip_left == 32'd0)
            begin
                rx_phase = PH_CHUNK_ID;
            end
        end
        else if (rx_phase == PH_DATA)
        begin
            // Collect one frame; a frame cut short by the data size is dropped.
            frame_acc = frame_acc | ({24'd0, b} << (8 * frame_pos));
            cnt       = frame_pos + 1;
            data_left = data_left - 32'd1;
            per_frame = (is_wide ? 2 : 1) * (is_stereo ? 2 : 1);
            if (cnt >= per_frame)
            begin
                if (is_wide)
                begin
                    l = frame_acc[15:0];
                    r = is_stereo ? frame_acc[31:16] : 16'd0;
                end
                else
                begin
                    l = {8'd0, frame_acc[7:0]};
                    r = is_stereo ? {8'd0, frame_acc[15:8]} : 16'd0;
                end
                frame_acc = 32'd0;
                frame_pos = 2'd0;
                if (data_left == 32'd0)
                begin
                    rx_phase = PH_DONE;
                end
                res     = make_result(ST_FRAME, l, r, data_left == 32'd0);
                has_res = 1'b1;
            end
            else
            begin
                frame_pos = 2'(cnt);
                if (data_left == 32'd0)
                begin
                    frame_acc = 32'd0;
                    frame_pos = 2'd0;
                    rx_phase  = PH_DONE;
                    res       = make_result(ST_PARTIAL_END, 16'd0, 16'd0, 1'b1);
                    has_res   = 1'b1;
                end
            end
        end
        else
        begin
            // Header fields are gathered little-endian, two or four bytes wide.
            word_acc = word_acc | ({24'd0, b} << (8 * word_pos));
            cnt      = word_pos + 1;
            need     = (rx_phase == PH_FORMAT || rx_phase == PH_CHANNELS ||
                        rx_phase == PH_ALIGN || rx_phase == PH_BITS) ? 2 : 4;
            if (cnt < need)
            begin
                word_pos = 2'(cnt);
            end
            else
            begin
                v        = word_acc;
                word_pos = 2'd0;
                word_acc = 32'd0;
                case (rx_phase)
                    PH_RIFF:
                    begin
                        if (v != ID_RIFF)
                        begin
                            bad = 1'b1;
                            err = ST_BAD_RIFF;
                        end
                        else
                        begin
                            rx_phase = PH_RIFF_SIZE;
                        end
                    end
                    PH_RIFF_SIZE:
                    begin
                        rx_phase = PH_WAVE;
                    end
                    PH_WAVE:
                    begin
                        if (v != ID_WAVE)
                        begin
                            bad = 1'b1;
                            err = ST_BAD_WAVE;
                        end
                        else
                        begin
                            rx_phase = PH_FMT_SCAN;
                        end
                    end
                    PH_FMT_SCAN:
                    begin
                        if (v == ID_FMT)
                        begin
                            rx_phase = PH_FMT_SIZE;
                        end
                    end
                    PH_FMT_SIZE:
                    begin
                        rx_phase = PH_FORMAT;
                        if (v == FMT_SIZE_BASIC)
                        begin
                            skip_left = 32'd0;
                        end
                        else if (v == FMT_SIZE_EXT)
                        begin
                            skip_left = EXTRA_EXT;
                        end
                        else if (v == FMT_SIZE_LONG)
                        begin
                            skip_left = EXTRA_LONG;
                        end
                        else
                        begin
                            bad = 1'b1;
                            err = ST_FMT_SIZE;
                        end
                    end
                    PH_FORMAT:
                    begin
                        if (v != FORMAT_PCM)
                        begin
                            bad = 1'b1;
                            err = ST_NOT_PCM;
                        end
                        else
                        begin
                            rx_phase = PH_CHANNELS;
                        end
                    end
                    PH_CHANNELS:
                    begin
                        if (v != CHANNELS_MONO && v != CHANNELS_DUAL)
                        begin
                            bad = 1'b1;
                            err = ST_CHANNELS;
                        end
                        else
                        begin
                            is_stereo = (v == CHANNELS_DUAL);
                            rx_phase  = PH_RATE;
                        end
                    end
                    PH_RATE:
                    begin
                        if (v == 32'd0)
                        begin
                            bad = 1'b1;
                            err = ST_ZERO_RATE;
                        end
                        else
                        begin
                            rate_seen = v;
                            rx_phase  = PH_BYTE_RATE;
                        end
                    end
                    PH_BYTE_RATE:
                    begin
                        rx_phase = PH_ALIGN;
                    end
                    PH_ALIGN:
                    begin
                        rx_phase = PH_BITS;
                    end
                    PH_BITS:
                    begin
                        if (v != BITS_NARROW && v != BITS_WIDE)
                        begin
                            bad = 1'b1;
                            err = ST_BITS;
                        end
                        else
                        begin
                            is_wide  = (v == BITS_WIDE);
                            rx_phase = (skip_left == 32'd0) ? PH_CHUNK_ID : PH_SKIP_EXTRA;
                        end
                    end
                    PH_CHUNK_ID:
                    begin
                        rx_phase = (v == ID_DATA) ? PH_DATA_SIZE : PH_CHUNK_SIZE;
                    end
                    PH_CHUNK_SIZE:
                    begin
                        skip_left = v;
                        rx_phase  = (v == 32'd0) ? PH_CHUNK_ID : PH_SKIP_CHUNK;
                    end
                    PH_DATA_SIZE:
                    begin
                        data_left = v;
                        frame_acc = 32'd0;
                        frame_pos = 2'd0;
                        rx_phase  = (v == 32'd0) ? PH_DONE : PH_DATA;
                    end
                    default:
                    begin
                        rx_phase = PH_ERROR;
                    end
                endcase
                if (bad)
                begin
                    rx_phase = PH_ERROR;
                    res      = make_result(err, 16'd0, 16'd0, 1'b0);
                    has_res  = 1'b1;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // File construction
    // ------------------------------------------------------------------------

    function automatic void put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
        begin
            file_octets.push_back(v[8 * i +: 8]);
        end
    endfunction

    function automatic logic [31:0] random_not(input logic [31:0] avoid);
        logic [31:0] w;
        w = $urandom();
        while (w == avoid)
        begin
            w = $urandom();
        end
        return w;
    endfunction

    // Sample bytes lean towards the signed and unsigned extremes.
    function automatic logic [7:0] data_octet(input int i, input logic fixed_head);
        logic [7:0] o;
        o = 8'($urandom());
        if (fixed_head && i < 4)
        begin
            case (i)
                0: o = 8'h00;
                1: o = 8'h80;
                2: o = 8'hFF;
                default: o = 8'h7F;
            endcase
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            case ($urandom_range(0, 3))
                0: o = 8'h00;
                1: o = 8'h80;
                2: o = 8'hFF;
                default: o = 8'h7F;
            endcase
        end
        return o;
    endfunction

    function automatic wav_desc_t plain_wav(input logic [15:0] chans,
                                            input logic [15:0] sample_bits,
                                            input int nbytes);
        wav_desc_t d;
        d.riff_id      = ID_RIFF;
        d.wave_id      = ID_WAVE;
        d.junk_words   = 8'd0;
        d.fmt_size     = FMT_SIZE_BASIC;
        d.fmt_code     = 16'(FORMAT_PCM);
        d.channels     = chans;
        d.rate         = 32'd44100;
        d.bits         = sample_bits;
        d.other_chunks = 8'd0;
        d.data_size    = 32'(nbytes);
        d.data_len     = 16'(nbytes);
        d.fixed_head   = 1'b1;
        return d;
    endfunction

    function automatic void build_wav(input wav_desc_t d);
        int clen;
        file_octets.delete();
        put_le(d.riff_id, 4);
        put_le($urandom(), 4);
        put_le(d.wave_id, 4);
        for (int i = 0; i < d.junk_words; i++)
        begin
            put_le(random_not(ID_FMT), 4);
        end
        put_le(ID_FMT, 4);
        put_le(d.fmt_size, 4);
        put_le(32'(d.fmt_code), 2);
        put_le(32'(d.channels), 2);
        put_le(d.rate, 4);
        put_le($urandom(), 4);
        put_le($urandom(), 2);
        put_le(32'(d.bits), 2);
        if (d.fmt_size == FMT_SIZE_EXT || d.fmt_size == FMT_SIZE_LONG)
        begin
            put_le($urandom(), 2);
            if (d.fmt_size == FMT_SIZE_LONG)
            begin
                for (int i = 0; i < 22; i++)
                begin
                    file_octets.push_back(8'($urandom()));
                end
            end
        end
        // Chunks that the parser must skip by their size, some of them empty.
        for (int i = 0; i < d.other_chunks; i++)
        begin
            clen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            put_le(random_not(ID_DATA), 4);
            put_le(32'(clen), 4);
            for (int k = 0; k < clen; k++)
            begin
                file_octets.push_back(8'($urandom()));
            end
        end
        put_le(ID_DATA, 4);
        put_le(d.data_size, 4);
        for (int i = 0; i < d.data_len; i++)
        begin
            file_octets.push_back(data_octet(i, d.fixed_head));
        end
    endfunction

    function automatic wav_desc_t random_wav();
        wav_desc_t d;
        int        per_frame;
        int        frames;
        d = plain_wav(16'($urandom_range(1, 2)), ($urandom_range(0, 1) != 0) ? 16'd16 : 16'd8, 0);
        case ($urandom_range(0, 2))
            0: d.fmt_size = FMT_SIZE_BASIC;
            1: d.fmt_size = FMT_SIZE_EXT;
            default: d.fmt_size = FMT_SIZE_LONG;
        endcase
        d.junk_words   = 8'($urandom_range(0, 2));
        d.other_chunks = 8'($urandom_range(0, 2));
        case ($urandom_range(0, 7))
            0: d.rate = 32'd1;
            1: d.rate = 32'hFFFF_FFFF;
            default: d.rate = random_not(32'd0);
        endcase
        d.fixed_head = ($urandom_range(0, 3) == 0);
        per_frame = (d.bits == 16'd16 ? 2 : 1) * (d.channels == 16'd2 ? 2 : 1);
        frames = ($urandom_range(0, 19) == 0) ? $urandom_range(16, 64) : $urandom_range(0, 8);
        d.data_size = 32'(frames * per_frame);
        if (per_frame > 1 && $urandom_range(0, 5) == 0)
        begin
            d.data_size = d.data_size + 32'($urandom_range(1, per_frame - 1));
        end
        d.data_len = 16'(d.data_size);
        if ($urandom_range(0, 3) == 0)
        begin
            d.data_len = d.data_len + 16'($urandom_range(1, 4));
        end
        // A file cut off long before its data size runs out.
        if ($urandom_range(0, 9) == 0)
        begin
            d.data_size = $urandom() | 32'h0001_0000;
            d.data_len  = 16'($urandom_range(0, 12));
        end
        return d;
    endfunction

    function automatic wav_desc_t corrupt_wav(input wav_desc_t d);
        wav_desc_t c;
        c = d;
        case ($urandom_range(0, 6))
            0: c.riff_id = random_not(ID_RIFF);
            1: c.wave_id = random_not(ID_WAVE);
            2: c.fmt_size = ($urandom_range(0, 1) != 0) ? 32'($urandom_range(0, 48)) : $urandom();
            3: c.fmt_code = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 4)) : 16'($urandom());
            4: c.channels = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 4)) : 16'($urandom());
            5: c.rate = 32'd0;
            default: c.bits = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 24)) : 16'($urandom());
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Input channel
    // ------------------------------------------------------------------------

    // Offers one byte, waits for the transaction and records its prediction.
    task automatic send_byte(input logic [7:0] value, input logic sof);
        bit      has_res;
        result_t res;
        if (!no_gaps && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5))
            begin
                @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        in_valid      <= 1'b1;
        file_byte     <= value;
        start_of_file <= sof;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        parse_byte(value, sof, has_res, res);
        if (has_res)
        begin
            pending_results.push_back(res);
        end
        bytes_sent++;
    endtask

    task automatic send_octets(input bit with_sof);
        for (int i = 0; i < file_octets.size(); i++)
        begin
            send_byte(file_octets[i], with_sof && i == 0);
        end
    endtask

    task automatic send_wav(input wav_desc_t d, input bit with_sof);
        build_wav(d);
        send_octets(with_sof);
    endtask

    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_byte(8'($urandom()), $urandom_range(0, 7) == 0);
        end
    endtask

    // Holds the input off until every predicted result has been taken.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Output channel and checking
    // ------------------------------------------------------------------------

    task automatic note_error(input string msg);
        error_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // The receiver picks a new pace mode whenever its pace counter runs out.
    always @(posedge clk)
    begin
        if (pace_left == 0)
        begin
            pace_mode <= pace_t'($urandom_range(0, 3));
            pace_left <= $urandom_range(32, 256);
        end
        else
        begin
            pace_left <= pace_left - 1;
        end
        case (pace_mode)
            PACE_FREE:   out_ready <= 1'b1;
            PACE_COIN:   out_ready <= 1'($urandom_range(0, 1));
            PACE_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            default:     out_ready <= cycle_count[3];
        endcase
    end

    // Each output transaction is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                note_error($sformatf("result %0d arrived with nothing pending", results_seen));
            end
            else
            begin
                head_result = pending_results.pop_front();
                if (status !== head_result.status)
                begin
                    note_error($sformatf("result %0d status %0d, want %0d",
                                         results_seen, status, head_result.status));
                end
                if (left_sample !== head_result.left_sample)
                begin
                    note_error($sformatf("result %0d left %0d, want %0d",
                                         results_seen, left_sample, head_result.left_sample));
                end
                if (right_sample !== head_result.right_sample)
                begin
                    note_error($sformatf("result %0d right %0d, want %0d",
                                         results_seen, right_sample, head_result.right_sample));
                end
                if (end_of_data !== head_result.end_of_data)
                begin
                    note_error($sformatf("result %0d end_of_data %b, want %b",
                                         results_seen, end_of_data, head_result.end_of_data));
                end
                if (stereo !== head_result.stereo)
                begin
                    note_error($sformatf("result %0d stereo %b, want %b",
                                         results_seen, stereo, head_result.stereo));
                end
                if (sixteen_bit !== head_result.sixteen_bit)
                begin
                    note_error($sformatf("result %0d sixteen_bit %b, want %b",
                                         results_seen, sixteen_bit, head_result.sixteen_bit));
                end
                if (sample_rate !== head_result.sample_rate)
                begin
                    note_error($sformatf("result %0d rate %0d, want %0d",
                                         results_seen, sample_rate, head_result.sample_rate));
                end
            end
            results_seen++;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("wav_pcm_stream_parser_top_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Bytes straight after reset are parsed as a file with no start byte.
    task automatic test_no_start_byte();
        send_wav(plain_wav(16'd1, 16'd8, 4), 1'b0);
        wait_for_results();
    endtask

    // All four sample layouts, every fmt size and the rate extremes.
    task automatic test_sample_formats();
        wav_desc_t d;
        no_gaps = 1'b1;
        d = plain_wav(16'd1, 16'd8, 6);
        d.rate = 32'd1;
        send_wav(d, 1'b1);
        d = plain_wav(16'd2, 16'd8, 6);
        d.fmt_size = FMT_SIZE_EXT;
        send_wav(d, 1'b1);
        no_gaps = 1'b0;
        d = plain_wav(16'd1, 16'd16, 6);
        d.fmt_size = FMT_SIZE_LONG;
        d.rate = 32'hFFFF_FFFF;
        send_wav(d, 1'b1);
        d = plain_wav(16'd2, 16'd16, 8);
        send_wav(d, 1'b1);
        wait_for_results();
    endtask

    // A file for each header error, two for the channel count; the rest of each file must be ignored.
    task automatic test_header_errors();
        wav_desc_t d;
        for (int k = 0; k < 8; k++)
        begin
            d = plain_wav(16'd2, 16'd16, 4);
            case (k)
                0: d.riff_id = random_not(ID_RIFF);
                1: d.wave_id = random_not(ID_WAVE);
                2: d.fmt_size = 32'd17;
                3: d.fmt_code = 16'd3;
                4: d.channels = 16'd0;
                5: d.channels = 16'd3;
                6: d.rate = 32'd0;
                default: d.bits = 16'd12;
            endcase
            send_wav(d, 1'b1);
        end
        wait_for_results();
    endtask

    // Data sizes that end inside a frame, and bytes after the data.
    task automatic test_partial_frames();
        wav_desc_t d;
        d = plain_wav(16'd2, 16'd16, 5);
        d.data_len = 16'd8;
        send_wav(d, 1'b1);
        send_wav(plain_wav(16'd1, 16'd16, 3), 1'b1);
        send_wav(plain_wav(16'd2, 16'd8, 3), 1'b1);
        wait_for_results();
    endtask

    // An empty data chunk ends the file with no result.
    task automatic test_empty_data();
        wav_desc_t d;
        d = plain_wav(16'd1, 16'd8, 0);
        d.data_len = 16'd4;
        send_wav(d, 1'b1);
        wait_for_results();
    endtask

    // Words before the fmt id and chunks to be skipped, empty ones among them.
    task automatic test_chunk_skipping();
        wav_desc_t d;
        d = plain_wav(16'd2, 16'd8, 4);
        d.junk_words = 8'd3;
        d.other_chunks = 8'd3;
        send_wav(d, 1'b1);
        d = plain_wav(16'd1, 16'd16, 4);
        d.fmt_size = FMT_SIZE_LONG;
        d.other_chunks = 8'd2;
        send_wav(d, 1'b1);
        wait_for_results();
    endtask

    // A file with no fmt id, then a start byte in the middle of data.
    task automatic test_restarts();
        wav_desc_t d;
        file_octets.delete();
        put_le(ID_RIFF, 4);
        put_le($urandom(), 4);
        put_le(ID_WAVE, 4);
        for (int i = 0; i < 12; i++)
        begin
            put_le(random_not(ID_FMT), 4);
        end
        send_octets(1'b1);
        d = plain_wav(16'd2, 16'd16, 40);
        d.data_len = 16'd6;
        send_wav(d, 1'b1);
        send_wav(plain_wav(16'd1, 16'd8, 3), 1'b1);
        wait_for_results();
    endtask

    // Mostly well-formed files with random content, some broken, some noise.
    task automatic test_random_files();
        int        first_byte;
        int        pick;
        wav_desc_t d;
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 19);
            no_gaps = ($urandom_range(0, 4) == 0);
            if (pick < 14)
            begin
                send_wav(random_wav(), $urandom_range(0, 15) != 0);
            end
            else if (pick < 17)
            begin
                d = corrupt_wav(random_wav());
                send_wav(d, 1'b1);
            end
            else
            begin
                send_noise($urandom_range(1, 30));
            end
            if ($urandom_range(0, 29) == 0)
            begin
                wait_for_results();
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        clear_parser();
        repeat (9)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;

        test_no_start_byte();
        test_sample_formats();
        test_header_errors();
        test_partial_frames();
        test_empty_data();
        test_chunk_skipping();
        test_restarts();
        test_random_files();

        wait_for_results();
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("wav_pcm_stream_parser_top_tb: clean");
        end
        else
        begin
            $display("wav_pcm_stream_parser_top_tb: errors");
        end
        $finish;
    end

endmodule
